// ===== src/uf_pkg.sv =====
// Shared constants and types for the union-find engine.
package uf_pkg;

	localparam int NODE_W          = 10;   // width of node_a / node_b
	localparam int ROOT_W          = 10;   // width of root result
	localparam int RED_STEPS       = 5;    // compare-subtract steps per reduce cycle
	localparam int SH_W            = $clog2(NODE_W);
	localparam int DEF_NODE_COUNT  = 1024;

	localparam logic KIND_FIND = 1'b0;
	localparam logic KIND_JOIN = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,   // post-reset sweep marking every entry as a root
		ST_IDLE,    // waiting for an item
		ST_RED,     // reducing node indexes modulo NODE_COUNT
		ST_FRD,     // first read of a find walk
		ST_FCHK,    // walking up toward the root, one entry per cycle
		ST_CCHK,    // compression walk, rewriting parents to the root
		ST_LINK,    // join: hang root(a) under root(b)
		ST_DONE     // result waiting for the output register
	} uf_state_t;

endpackage

// ===== src/union_find_engine.sv =====
// Sequence: a find walks from its node up to the root, then points each node on that path
//   at the root; a join adds the second find plus one link write when the two roots differ.
// Throughput: one item in flight; the next item is taken once the result moves into the
//   output register. Walk speed is one table entry per cycle on the single read port.
// Reset: arst_n clears control state, then a sweep marks all NODE_COUNT entries as roots,
//   one per cycle, with in_ready low until the sweep ends.
module union_find_engine #(
	parameter int NODE_COUNT = uf_pkg::DEF_NODE_COUNT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [uf_pkg::NODE_W-1:0] node_a,
	input  logic [uf_pkg::NODE_W-1:0] node_b,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [uf_pkg::ROOT_W-1:0] root,
	output logic                      same_set
);
	import uf_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT);
	// wide enough to hold a root index or the result field, whichever is larger
	localparam int XW    = (IDX_W > ROOT_W) ? IDX_W : ROOT_W;

	logic             mod_load;
	logic             mod_done;
	logic [IDX_W-1:0] na;
	logic [IDX_W-1:0] nb;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [IDX_W:0]   mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [IDX_W:0]   mem_rdata;
	logic             res_valid;
	logic             res_ready;
	logic [IDX_W-1:0] res_root;
	logic             res_same;
	logic [XW-1:0]    root_ext;

	logic              out_valid_q;
	logic [ROOT_W-1:0] root_q;
	logic              same_q;

	// index reduction: user keeps raw ports stable while in_valid is high; captured on accept
	uf_mod #(
		.NODE_COUNT(NODE_COUNT),
		.IDX_W     (IDX_W)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (mod_load),
		.raw_a (node_a),
		.raw_b (node_b),
		.done  (mod_done),
		.red_a (na),
		.red_b (nb)
	);

	// control: clear sweep, walks, compression and link
	uf_walker #(
		.NODE_COUNT(NODE_COUNT),
		.IDX_W     (IDX_W)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_kind  (kind),
		.mod_load (mod_load),
		.mod_done (mod_done),
		.na       (na),
		.nb       (nb),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_root (res_root),
		.res_same (res_same)
	);

	// parent table, root mark plus parent index per node
	uf_table #(
		.NODE_COUNT(NODE_COUNT),
		.IDX_W     (IDX_W)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register: frees the walker as soon as a result is parked here
	assign res_ready = !out_valid_q || out_ready;
	// root field carries the low bits of the root index (zero-extended for small tables)
	assign root_ext  = XW'(res_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			root_q <= root_ext[ROOT_W-1:0];
			same_q <= res_same;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign same_set  = same_q;

endmodule

// ===== src/uf_table.sv =====
// Parent table memory: one write port, one read port, registered read data.
module uf_table #(
	parameter int NODE_COUNT = uf_pkg::DEF_NODE_COUNT,
	parameter int IDX_W      = $clog2(NODE_COUNT)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [IDX_W:0]   wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W:0]   rdata
);
	import uf_pkg::*;

	// entry: [IDX_W] root mark, [IDX_W-1:0] parent index
	logic [IDX_W:0] mem [NODE_COUNT];
	logic [IDX_W:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/uf_mod.sv =====
// Reduces both raw node indexes modulo NODE_COUNT by restoring compare-subtract.
module uf_mod #(
	parameter int NODE_COUNT = uf_pkg::DEF_NODE_COUNT,
	parameter int IDX_W      = $clog2(NODE_COUNT)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [uf_pkg::NODE_W-1:0] raw_a,
	input  logic [uf_pkg::NODE_W-1:0] raw_b,
	output logic                      done,
	output logic [IDX_W-1:0]          red_a,
	output logic [IDX_W-1:0]          red_b
);
	import uf_pkg::*;

	localparam int CW = $clog2(NODE_COUNT + 1) + NODE_W;

	logic          busy_q;
	logic          pass_q;
	logic          done_q;
	logic [CW-1:0] va_q;
	logic [CW-1:0] vb_q;
	logic [CW-1:0] va_nx;
	logic [CW-1:0] vb_nx;

	// high pass handles shifts NODE_W-1..RED_STEPS, low pass RED_STEPS-1..0
	always_comb begin
		logic [CW-1:0]   d;
		logic [SH_W-1:0] sh;
		va_nx = va_q;
		vb_nx = vb_q;
		for (int j = 0; j < RED_STEPS; j++) begin
			sh = pass_q ? SH_W'(RED_STEPS - 1 - j) : SH_W'(2 * RED_STEPS - 1 - j);
			d  = CW'(NODE_COUNT) << sh;
			if (va_nx >= d) begin
				va_nx = va_nx - d;
			end
			if (vb_nx >= d) begin
				vb_nx = vb_nx - d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pass_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && pass_q;
			if (load) begin
				busy_q <= 1'b1;
				pass_q <= 1'b0;
			end else if (busy_q) begin
				pass_q <= 1'b1;
				if (pass_q) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			va_q <= CW'(raw_a);
			vb_q <= CW'(raw_b);
		end else if (busy_q) begin
			va_q <= va_nx;
			vb_q <= vb_nx;
		end
	end

	assign done  = done_q;
	assign red_a = va_q[IDX_W-1:0];
	assign red_b = vb_q[IDX_W-1:0];

endmodule

// ===== src/uf_walker.sv =====
// Sequencer: table clear, find walks with path compression, join link.
module uf_walker #(
	parameter int NODE_COUNT = uf_pkg::DEF_NODE_COUNT,
	parameter int IDX_W      = $clog2(NODE_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_kind,
	output logic             mod_load,
	input  logic             mod_done,
	input  logic [IDX_W-1:0] na,
	input  logic [IDX_W-1:0] nb,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [IDX_W:0]   mem_wdata,
	output logic [IDX_W-1:0] mem_raddr,
	input  logic [IDX_W:0]   mem_rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [IDX_W-1:0] res_root,
	output logic             res_same
);
	import uf_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

	uf_state_t        state_q;
	uf_state_t        state_nx;
	logic [IDX_W-1:0] clr_q;
	logic             sel_b_q;
	logic             kind_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] top_q;
	logic [IDX_W-1:0] ra_q;
	logic [IDX_W-1:0] res_root_q;
	logic             res_same_q;

	logic             rd_root;
	logic [IDX_W-1:0] rd_par;
	logic [IDX_W-1:0] start;
	logic             find_done;
	logic [IDX_W-1:0] fin_root;
	uf_state_t        fin_state;

	assign rd_root = mem_rdata[IDX_W];
	assign rd_par  = mem_rdata[IDX_W-1:0];
	assign start   = sel_b_q ? nb : na;

	assign find_done = ((state_q == ST_FCHK) && rd_root && (cur_q == start)) ||
	                   ((state_q == ST_CCHK) && (rd_par == top_q));
	assign fin_root  = (state_q == ST_FCHK) ? cur_q : top_q;

	always_comb begin
		if (!sel_b_q && (kind_q == KIND_JOIN)) begin
			fin_state = ST_FRD;
		end else if (sel_b_q && (ra_q != fin_root)) begin
			fin_state = ST_LINK;
		end else begin
			fin_state = ST_DONE;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_RED;
			end
			ST_RED: begin
				if (mod_done) state_nx = ST_FRD;
			end
			ST_FRD: begin
				state_nx = ST_FCHK;
			end
			ST_FCHK: begin
				if (find_done) state_nx = fin_state;
				else if (rd_root) state_nx = ST_CCHK;
			end
			ST_CCHK: begin
				if (find_done) state_nx = fin_state;
			end
			ST_LINK: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// outputs and memory port drive
	always_comb begin
		in_ready  = 1'b0;
		mod_load  = 1'b0;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = {1'b0, top_q};
		mem_raddr = start;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {1'b1, {IDX_W{1'b0}}};
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				mod_load = in_valid;
			end
			ST_RED: begin
			end
			ST_FRD: begin
				mem_raddr = start;
			end
			ST_FCHK: begin
				mem_raddr = rd_root ? start : rd_par;
			end
			ST_CCHK: begin
				// write the node just read, read its old parent; never the same entry
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = {1'b0, top_q};
				mem_raddr = rd_par;
			end
			ST_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = ra_q;
				mem_wdata = {1'b0, res_root_q};
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			sel_b_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_RED) begin
				sel_b_q <= 1'b0;
			end else if (find_done && !sel_b_q) begin
				sel_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			kind_q <= in_kind;
		end
		if (state_q == ST_FRD) begin
			cur_q <= start;
		end
		if (state_q == ST_FCHK) begin
			if (rd_root) begin
				top_q <= cur_q;
				cur_q <= start;
			end else begin
				cur_q <= rd_par;
			end
		end
		if (state_q == ST_CCHK) begin
			cur_q <= rd_par;
		end
		if (find_done) begin
			res_root_q <= fin_root;
			res_same_q <= sel_b_q && (ra_q == fin_root);
			if (!sel_b_q) begin
				ra_q <= fin_root;
			end
		end
	end

	assign res_root = res_root_q;
	assign res_same = res_same_q;

endmodule

// ===== src/uf_checker.sv =====
// Port-level checks for the union-find engine, bound to the top level.
module uf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [uf_pkg::ROOT_W-1:0] root,
	input logic                      same_set
);
	import uf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root) && $stable(same_set))
		else $error("result changed while stalled");

	// clear sweep keeps input closed right after reset
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("item accepted during table clear");

	// one item in flight
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

	// a fresh result only appears after the engine was busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind union_find_engine uf_checker u_chk (.*);
